// ----- design/assert_macros.svh -----
// Assertion shorthands shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LBPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbpc assertion failed");

// Next-cycle implication.
`define LBPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbpc assertion failed");

`endif

// ----- design/lbpc_pkg.sv -----
package lbpc_pkg;

  localparam int CW = 16;   // coordinate width
  localparam int DW = 17;   // coordinate difference width
  localparam int TW = 32;   // edge parameter width, Q16.16
  localparam int TF = 16;   // edge parameter fraction bits

  localparam logic signed [TW-1:0] T_ONE     = 32'sh0001_0000;
  localparam logic signed [TW-1:0] T_POS_INF = 32'sh7FFF_FFFF;
  localparam logic signed [TW-1:0] T_NEG_INF = 32'sh8000_0000;

  localparam logic [1:0] CFG_XMIN = 2'd0;
  localparam logic [1:0] CFG_YMIN = 2'd1;
  localparam logic [1:0] CFG_XMAX = 2'd2;
  localparam logic [1:0] CFG_YMAX = 2'd3;

  // One edge, already classified against the window.
  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic signed [CW-1:0] inx;
    logic signed [CW-1:0] iny;
    logic signed [CW-1:0] outx;
    logic signed [CW-1:0] outy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] nox;
    logic signed [DW-1:0] noy;
    logic signed [DW-1:0] nix;
    logic signed [DW-1:0] niy;
    logic                 xin;
    logic                 yin;
  } lbpc_job_t;

endpackage

// ----- design/lbpc_front.sv -----
module lbpc_front import lbpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_vert_x,
  input  logic signed [CW-1:0] in_vert_y,
  input  logic                 in_start_flag,
  input  logic signed [CW-1:0] win_xmin,
  input  logic signed [CW-1:0] win_ymin,
  input  logic signed [CW-1:0] win_xmax,
  input  logic signed [CW-1:0] win_ymax,
  input  logic                 q_full,
  output logic                 q_push,
  output lbpc_job_t            q_job
);

  logic signed [CW-1:0] prev_x_r, prev_x_nxt;
  logic signed [CW-1:0] prev_y_r, prev_y_nxt;
  logic signed [DW-1:0] dx, dy;
  logic                 xfwd, yfwd, acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc && !in_start_flag;

  assign dx = {in_vert_x[CW-1], in_vert_x} - {prev_x_r[CW-1], prev_x_r};
  assign dy = {in_vert_y[CW-1], in_vert_y} - {prev_y_r[CW-1], prev_y_r};

  // Direction picks which window sides the edge enters and leaves through.
  assign xfwd = (dx > 0) || ((dx == '0) && (prev_x_r > win_xmax));
  assign yfwd = (dy > 0) || ((dy == '0) && (prev_y_r > win_ymax));

  always_comb begin
    q_job.x1   = prev_x_r;
    q_job.y1   = prev_y_r;
    q_job.x2   = in_vert_x;
    q_job.y2   = in_vert_y;
    q_job.dx   = dx;
    q_job.dy   = dy;
    q_job.inx  = xfwd ? win_xmin : win_xmax;
    q_job.outx = xfwd ? win_xmax : win_xmin;
    q_job.iny  = yfwd ? win_ymin : win_ymax;
    q_job.outy = yfwd ? win_ymax : win_ymin;
    q_job.nox  = {q_job.outx[CW-1], q_job.outx} - {prev_x_r[CW-1], prev_x_r};
    q_job.noy  = {q_job.outy[CW-1], q_job.outy} - {prev_y_r[CW-1], prev_y_r};
    q_job.nix  = {q_job.inx[CW-1], q_job.inx} - {prev_x_r[CW-1], prev_x_r};
    q_job.niy  = {q_job.iny[CW-1], q_job.iny} - {prev_y_r[CW-1], prev_y_r};
    q_job.xin  = (prev_x_r >= win_xmin) && (prev_x_r <= win_xmax);
    q_job.yin  = (prev_y_r >= win_ymin) && (prev_y_r <= win_ymax);
  end

  assign prev_x_nxt = acc ? in_vert_x : prev_x_r;
  assign prev_y_nxt = acc ? in_vert_y : prev_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
    end else begin
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
    end
  end

endmodule

// ----- design/lbpc_queue.sv -----
module lbpc_queue import lbpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lbpc_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output lbpc_job_t pop_job
);

  lbpc_job_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_job = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/lbpc_div.sv -----
module lbpc_div import lbpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 busy,
  output logic                 done,
  output logic signed [TW-1:0] quo
);

  // Restoring division of |num|*2^16 by |den|, one quotient bit per cycle.
  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [TW-1:0] n_r, n_nxt;
  logic [CW-1:0] d_r, d_nxt;
  logic [CW:0]   rem_r, rem_nxt;
  logic [TW-1:0] q_r, q_nxt;
  logic          neg_r, neg_nxt;
  logic [DW-1:0] num_mag, den_mag;
  logic [CW:0]   rem_sh;
  logic [CW+1:0] diff;

  assign num_mag = num[DW-1] ? (~num + 1'b1) : num;
  assign den_mag = den[DW-1] ? (~den + 1'b1) : den;
  assign rem_sh  = {rem_r[CW-1:0], n_r[TW-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, d_r};

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      n_nxt    = {num_mag[CW-1:0], {TF{1'b0}}};
      d_nxt    = den_mag[CW-1:0];
      rem_nxt  = '0;
      q_nxt    = '0;
      neg_nxt  = num[DW-1] ^ den[DW-1];
    end else if (busy_r) begin
      n_nxt   = {n_r[TW-2:0], 1'b0};
      rem_nxt = diff[CW+1] ? rem_sh : diff[CW:0];
      q_nxt   = {q_r[TW-2:0], ~diff[CW+1]};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  assign busy = busy_r || fin_r;
  assign done = fin_r;

  // Saturate the signed quotient to the Q16.16 range.
  always_comb begin
    if (!neg_r) begin
      quo = q_r[TW-1] ? T_POS_INF : $signed(q_r);
    end else if (q_r > 32'h8000_0000) begin
      quo = T_NEG_INF;
    end else begin
      quo = $signed(~q_r + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

// ----- design/lbpc_back.sv -----
module lbpc_back import lbpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  lbpc_job_t            q_job,
  output logic                 q_pop,
  output logic                 div_start,
  output logic signed [DW-1:0] div_num,
  output logic signed [DW-1:0] div_den,
  input  logic                 div_done,
  input  logic signed [TW-1:0] div_quo,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] out_clip_x,
  output logic signed [CW-1:0] out_clip_y,
  output logic                 out_run_last
);

`include "assert_macros.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DOX  = 4'd1;
  localparam logic [3:0] S_DOY  = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_DIX  = 4'd4;
  localparam logic [3:0] S_DIY  = 4'd5;
  localparam logic [3:0] S_PLAN = 4'd6;
  localparam logic [3:0] S_PT   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic [1:0] M_CONST = 2'd0;
  localparam logic [1:0] M_IX    = 2'd1;
  localparam logic [1:0] M_IY    = 2'd2;

  logic [3:0]           state_r, state_nxt;
  lbpc_job_t            job_r, job_nxt;
  logic                 wait_r, wait_nxt;
  logic signed [TW-1:0] toutx_r, toutx_nxt, touty_r, touty_nxt;
  logic signed [TW-1:0] tinx_r, tinx_nxt, tiny_r, tiny_nxt;
  logic [2:0]           en_r, en_nxt;
  logic [1:0]           md_r [3];
  logic [1:0]           md_nxt [3];
  logic signed [CW-1:0] px_r [3];
  logic signed [CW-1:0] px_nxt [3];
  logic signed [CW-1:0] py_r [3];
  logic signed [CW-1:0] py_nxt [3];
  logic signed [TW-1:0] pt_r [3];
  logic signed [TW-1:0] pt_nxt [3];
  logic [1:0]           k_r, k_nxt;
  logic signed [34:0]   prod_r, prod_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                 out_last_r, out_last_nxt;

  logic signed [TW-1:0] t1out, t2out, t2in, tsel;
  logic [TF:0]          tc;
  logic signed [DW-1:0] dsel;
  logic signed [35:0]   rnd;
  logic signed [19:0]   qv;
  logic signed [CW-1:0] base;
  logic signed [20:0]   sum;
  logic signed [CW-1:0] icoord;
  logic                 slot_last, out_free, out_load;

  assign t1out = (toutx_r < touty_r) ? toutx_r : touty_r;
  assign t2out = (toutx_r < touty_r) ? touty_r : toutx_r;
  assign t2in  = (tinx_r < tiny_r) ? tiny_r : tinx_r;

  // Interpolation: clamp t to [0,1], scale the delta, round half up.
  assign tsel = pt_r[k_r];
  always_comb begin
    if (tsel < 0) begin
      tc = '0;
    end else if (tsel > T_ONE) begin
      tc = T_ONE[TF:0];
    end else begin
      tc = tsel[TF:0];
    end
  end
  assign dsel   = (md_r[k_r] == M_IX) ? job_r.dx : job_r.dy;
  assign rnd    = {prod_r[34], prod_r} + 36'sd32768;
  assign qv     = rnd[35:16];
  assign base   = (md_r[k_r] == M_IX) ? job_r.x1 : job_r.y1;
  assign sum    = {{5{base[CW-1]}}, base} + {qv[19], qv};
  always_comb begin
    if (sum > 21'sd32767) begin
      icoord = 16'sh7FFF;
    end else if (sum < -21'sd32768) begin
      icoord = 16'sh8000;
    end else begin
      icoord = sum[CW-1:0];
    end
  end

  assign slot_last = (k_r == 2'd2) || ((k_r == 2'd1) && !en_r[2]) ||
                     ((k_r == 2'd0) && !en_r[1] && !en_r[2]);
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == S_OUT) && out_free;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    wait_nxt      = wait_r;
    toutx_nxt     = toutx_r;
    touty_nxt     = touty_r;
    tinx_nxt      = tinx_r;
    tiny_nxt      = tiny_r;
    en_nxt        = en_r;
    md_nxt        = md_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pt_nxt        = pt_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    div_num       = job_r.nox;
    div_den       = job_r.dx;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          state_nxt = S_DOX;
        end
      end
      S_DOX: begin
        div_num = job_r.nox;
        div_den = job_r.dx;
        if (job_r.dx == '0) begin
          toutx_nxt = job_r.xin ? T_POS_INF : T_NEG_INF;
          state_nxt = S_DOY;
        end else if (!wait_r) begin
          div_start = 1'b1;
          wait_nxt  = 1'b1;
        end else if (div_done) begin
          toutx_nxt = div_quo;
          wait_nxt  = 1'b0;
          state_nxt = S_DOY;
        end
      end
      S_DOY: begin
        div_num = job_r.noy;
        div_den = job_r.dy;
        if (job_r.dy == '0) begin
          touty_nxt = job_r.yin ? T_POS_INF : T_NEG_INF;
          state_nxt = S_CMP;
        end else if (!wait_r) begin
          div_start = 1'b1;
          wait_nxt  = 1'b1;
        end else if (div_done) begin
          touty_nxt = div_quo;
          wait_nxt  = 1'b0;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = (t2out > 0) ? S_DIX : S_IDLE;
      end
      S_DIX: begin
        div_num = job_r.nix;
        div_den = job_r.dx;
        if (job_r.dx == '0) begin
          tinx_nxt  = T_NEG_INF;
          state_nxt = S_DIY;
        end else if (!wait_r) begin
          div_start = 1'b1;
          wait_nxt  = 1'b1;
        end else if (div_done) begin
          tinx_nxt  = div_quo;
          wait_nxt  = 1'b0;
          state_nxt = S_DIY;
        end
      end
      S_DIY: begin
        div_num = job_r.niy;
        div_den = job_r.dy;
        if (job_r.dy == '0) begin
          tiny_nxt  = T_NEG_INF;
          state_nxt = S_PLAN;
        end else if (!wait_r) begin
          div_start = 1'b1;
          wait_nxt  = 1'b1;
        end else if (div_done) begin
          tiny_nxt  = div_quo;
          wait_nxt  = 1'b0;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        // Slot 0: turning corner or entering point, slot 1: exit point or
        // endpoint, slot 2: outgoing corner.
        en_nxt    = 3'b000;
        md_nxt[0] = M_CONST;
        md_nxt[1] = M_CONST;
        md_nxt[2] = M_CONST;
        px_nxt[0] = job_r.inx;
        py_nxt[0] = job_r.outy;
        pt_nxt[0] = tinx_r;
        px_nxt[1] = job_r.x2;
        py_nxt[1] = job_r.y2;
        pt_nxt[1] = toutx_r;
        px_nxt[2] = job_r.outx;
        py_nxt[2] = job_r.outy;
        pt_nxt[2] = t2out;
        if (t1out < t2in) begin
          en_nxt[0] = (t1out > 0) && (t1out <= T_ONE);
          if (tinx_r < tiny_r) begin
            px_nxt[0] = job_r.outx;
            py_nxt[0] = job_r.iny;
          end
        end else if ((t1out > 0) && (t2in <= T_ONE)) begin
          en_nxt[0] = (t2in >= 0);
          if (tinx_r > tiny_r) begin
            md_nxt[0] = M_IY;
            px_nxt[0] = job_r.inx;
            pt_nxt[0] = tinx_r;
          end else begin
            md_nxt[0] = M_IX;
            py_nxt[0] = job_r.iny;
            pt_nxt[0] = tiny_r;
          end
          en_nxt[1] = 1'b1;
          if (t1out <= T_ONE) begin
            if (toutx_r < touty_r) begin
              md_nxt[1] = M_IY;
              px_nxt[1] = job_r.outx;
              pt_nxt[1] = toutx_r;
            end else begin
              md_nxt[1] = M_IX;
              py_nxt[1] = job_r.outy;
              pt_nxt[1] = touty_r;
            end
          end
        end
        en_nxt[2] = (t2out <= T_ONE);
        k_nxt     = 2'd0;
        state_nxt = S_PT;
      end
      S_PT: begin
        if (en_r[k_r]) begin
          prod_nxt  = $signed({1'b0, tc}) * dsel;
          state_nxt = S_OUT;
        end else if (k_r == 2'd2) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = (md_r[k_r] == M_IX) ? icoord : px_r[k_r];
          out_y_nxt     = (md_r[k_r] == M_IY) ? icoord : py_r[k_r];
          out_last_nxt  = slot_last;
          if (k_r == 2'd2) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_PT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_clip_x   = out_x_r;
  assign out_clip_y   = out_y_r;
  assign out_run_last = out_last_r;

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    toutx_r  <= toutx_nxt;
    touty_r  <= touty_nxt;
    tinx_r   <= tinx_nxt;
    tiny_r   <= tiny_nxt;
    en_r     <= en_nxt;
    md_r     <= md_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    pt_r     <= pt_nxt;
    k_r      <= k_nxt;
    prod_r   <= prod_nxt;
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LBPC_ASSERT_IMPL(a_pop_idle, q_pop, (state_r == S_IDLE) && !q_empty)
  `LBPC_ASSERT_IMPL(a_done_waits, div_done,
      wait_r && ((state_r == S_DOX) || (state_r == S_DOY) ||
                 (state_r == S_DIX) || (state_r == S_DIY)))
  `LBPC_ASSERT_NEXT(a_load_shows, out_load, out_valid_r)

endmodule

// ----- design/liang_barsky_polygon_clip.sv -----
// Liang-Barsky polygon clipper against the window set by the four cfg
// registers (index 0..3: xmin, ymin, xmax, ymax). Send the polygon's last
// vertex first with start_flag set; each later vertex closes one edge and
// yields zero to three points, the last marked by out_run_last. A front
// stage classifies each edge and queues it (two deep); the back end works
// one edge at a time on a shared radix-2 divider. For each edge it first
// divides for the two exit parameters, skipping the divider for a zero
// delta, then for the entry parameters when the edge can reach the window,
// then emits each enabled output slot in turn and skips the rest; the
// output handshake can stall the emission.
module liang_barsky_polygon_clip import lbpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_vert_x,
  input  logic signed [CW-1:0] in_vert_y,
  input  logic                 in_start_flag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] out_clip_x,
  output logic signed [CW-1:0] out_clip_y,
  output logic                 out_run_last
);

  logic signed [CW-1:0] xmin_r, xmin_nxt, ymin_r, ymin_nxt;
  logic signed [CW-1:0] xmax_r, xmax_nxt, ymax_r, ymax_nxt;
  logic                 q_full, q_push, q_pop, q_empty;
  lbpc_job_t            push_job, pop_job;
  logic                 div_start, div_busy, div_done;
  logic signed [DW-1:0] div_num, div_den;
  logic signed [TW-1:0] div_quo;

  always_comb begin
    xmin_nxt = xmin_r;
    ymin_nxt = ymin_r;
    xmax_nxt = xmax_r;
    ymax_nxt = ymax_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_XMIN: xmin_nxt = cfg_wdata;
        CFG_YMIN: ymin_nxt = cfg_wdata;
        CFG_XMAX: xmax_nxt = cfg_wdata;
        CFG_YMAX: ymax_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= '0;
      ymin_r <= '0;
      xmax_r <= 16'sh7FFF;
      ymax_r <= 16'sh7FFF;
    end else begin
      xmin_r <= xmin_nxt;
      ymin_r <= ymin_nxt;
      xmax_r <= xmax_nxt;
      ymax_r <= ymax_nxt;
    end
  end

  lbpc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_vert_x, .in_vert_y, .in_start_flag,
    .win_xmin (xmin_r), .win_ymin (ymin_r), .win_xmax (xmax_r), .win_ymax (ymax_r),
    .q_full, .q_push, .q_job (push_job)
  );

  lbpc_queue u_queue (
    .clk, .rst_n, .push (q_push), .push_job, .full (q_full),
    .pop (q_pop), .empty (q_empty), .pop_job
  );

  lbpc_div u_div (
    .clk, .rst_n, .start (div_start), .num (div_num), .den (div_den),
    .busy (div_busy), .done (div_done), .quo (div_quo)
  );

  lbpc_back u_back (
    .clk, .rst_n, .q_empty, .q_job (pop_job), .q_pop,
    .div_start, .div_num, .div_den, .div_done, .div_quo,
    .out_valid, .out_ready, .out_clip_x, .out_clip_y, .out_run_last
  );

  `include "assert_macros.svh"

  `LBPC_ASSERT_IMPL(a_div_start_free, div_start, !div_busy)

endmodule
